// File: src/sfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash command sequencer package
// Shared types, codes and constants for the front end, the descriptor queue
// and the action sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  localparam int ADDR_W = 24;
  localparam int BYTE_W = 8;
  localparam int ACT_W  = 2;
  localparam int REQ_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Page size default; must be a power of two
  localparam int DEF_PAGE_BYTES = 256;

  // Descriptor queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Request types
  localparam logic [REQ_W-1:0] REQ_PROGRAM = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SECTOR  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BULK    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RDID    = 3'd4;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_SEND  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RAISE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WAIT  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_OP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BULK_OP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUMMY     = 2'd2;

  localparam logic [BYTE_W-1:0] RST_SECTOR_OP = 8'hD8;
  localparam logic [BYTE_W-1:0] RST_BULK_OP   = 8'hC7;
  localparam logic [BYTE_W-1:0] RST_DUMMY     = 8'hFF;

  // Flash instructions
  localparam logic [BYTE_W-1:0] OP_WREN    = 8'h06;
  localparam logic [BYTE_W-1:0] OP_PROGRAM = 8'h02;
  localparam logic [BYTE_W-1:0] OP_READ    = 8'h03;
  localparam logic [BYTE_W-1:0] OP_RDID    = 8'h9F;

  // Action slots of one transaction, emitted lowest first
  localparam int NUM_SLOTS = 14;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_CLOSE_RAISE = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_CLOSE_WAIT  = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_RD_RAISE    = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_WREN_SEND   = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_WREN_RAISE  = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_OPCODE      = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_HI     = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_MID    = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_LO     = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_BODY0       = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_BODY1       = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_BODY2       = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_RAISE  = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_WAIT   = 4'd13;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // One classified request: which actions to emit and their bytes
  typedef struct packed {
    slot_mask_t        slots;
    logic [BYTE_W-1:0] opcode;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] body;
  } sfcs_desc_t;

  function automatic slot_mask_t slot_bit(input logic [SLOT_W-1:0] s);
    slot_bit = slot_mask_t'(1) << s;
  endfunction

endpackage

// File: src/sfcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash command sequencer front end
// Accepts requests, tracks the run state and the cursor, holds the
// configuration registers and turns each request into an action descriptor.
// ----------------------------------------------------------------------------
module sfcs_front import sfcs_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [ADDR_W-1:0]    address,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 first,
  input  logic                 final_req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 q_full,
  output logic                 q_push,
  output sfcs_desc_t           q_wdata
);

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

  logic [ADDR_W-1:0] write_cursor, write_cursor_next;
  logic              program_open, program_open_next;
  logic              read_open, read_open_next;
  logic [BYTE_W-1:0] sector_op, bulk_op, dummy_value;

  logic              known;
  slot_mask_t        close_mask;
  logic [ADDR_W-1:0] base, base_inc;
  logic              do_open, tail;
  sfcs_desc_t        desc;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && known;
  assign q_wdata  = desc;

  // Classify the request
  always_comb begin
    close_mask = '0;
    if (program_open) close_mask = slot_bit(SLOT_CLOSE_RAISE) | slot_bit(SLOT_CLOSE_WAIT);
    if (read_open)    close_mask = close_mask | slot_bit(SLOT_RD_RAISE);

    base     = first ? address : write_cursor;
    base_inc = base + ADDR_W'(1);

    known             = 1'b1;
    do_open           = 1'b0;
    tail              = 1'b0;
    desc              = '0;
    write_cursor_next = write_cursor;
    program_open_next = program_open;
    read_open_next    = read_open;

    case (req_type)
      REQ_PROGRAM: begin
        do_open = first || !program_open;
        tail    = final_req || ((base_inc & PAGE_MASK) == '0);
        desc.body  = data_byte;
        desc.slots = slot_bit(SLOT_BODY0);
        if (do_open) begin
          desc.slots  = desc.slots | close_mask | slot_bit(SLOT_WREN_SEND)
                      | slot_bit(SLOT_WREN_RAISE) | slot_bit(SLOT_OPCODE)
                      | slot_bit(SLOT_ADDR_HI) | slot_bit(SLOT_ADDR_MID)
                      | slot_bit(SLOT_ADDR_LO);
          desc.opcode = OP_PROGRAM;
          desc.addr   = base;
        end
        if (tail) desc.slots = desc.slots | slot_bit(SLOT_TAIL_RAISE) | slot_bit(SLOT_TAIL_WAIT);
        write_cursor_next = base_inc;
        program_open_next = !tail;
        read_open_next    = 1'b0;
      end
      REQ_READ: begin
        do_open = first || !read_open;
        desc.body  = dummy_value;
        desc.slots = slot_bit(SLOT_BODY0);
        if (do_open) begin
          desc.slots  = desc.slots | close_mask | slot_bit(SLOT_OPCODE)
                      | slot_bit(SLOT_ADDR_HI) | slot_bit(SLOT_ADDR_MID)
                      | slot_bit(SLOT_ADDR_LO);
          desc.opcode = OP_READ;
          desc.addr   = base;
        end
        if (final_req) desc.slots = desc.slots | slot_bit(SLOT_TAIL_RAISE);
        write_cursor_next = base_inc;
        read_open_next    = !final_req;
        program_open_next = 1'b0;
      end
      REQ_SECTOR: begin
        desc.slots  = close_mask | slot_bit(SLOT_WREN_SEND) | slot_bit(SLOT_WREN_RAISE)
                    | slot_bit(SLOT_OPCODE) | slot_bit(SLOT_ADDR_HI)
                    | slot_bit(SLOT_ADDR_MID) | slot_bit(SLOT_ADDR_LO)
                    | slot_bit(SLOT_TAIL_RAISE) | slot_bit(SLOT_TAIL_WAIT);
        desc.opcode = sector_op;
        desc.addr   = address;
        program_open_next = 1'b0;
        read_open_next    = 1'b0;
      end
      REQ_BULK: begin
        desc.slots  = close_mask | slot_bit(SLOT_WREN_SEND) | slot_bit(SLOT_WREN_RAISE)
                    | slot_bit(SLOT_OPCODE) | slot_bit(SLOT_TAIL_RAISE)
                    | slot_bit(SLOT_TAIL_WAIT);
        desc.opcode = bulk_op;
        program_open_next = 1'b0;
        read_open_next    = 1'b0;
      end
      REQ_RDID: begin
        desc.slots  = close_mask | slot_bit(SLOT_OPCODE) | slot_bit(SLOT_BODY0)
                    | slot_bit(SLOT_BODY1) | slot_bit(SLOT_BODY2)
                    | slot_bit(SLOT_TAIL_RAISE);
        desc.opcode = OP_RDID;
        desc.body   = dummy_value;
        program_open_next = 1'b0;
        read_open_next    = 1'b0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Run state, updated on each accepted known request
  always_ff @(posedge clk) begin
    if (rst) begin
      write_cursor <= '0;
      program_open <= 1'b0;
      read_open    <= 1'b0;
    end else if (q_push) begin
      write_cursor <= write_cursor_next;
      program_open <= program_open_next;
      read_open    <= read_open_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_op   <= RST_SECTOR_OP;
      bulk_op     <= RST_BULK_OP;
      dummy_value <= RST_DUMMY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECTOR_OP: sector_op   <= cfg_wdata;
        CFG_BULK_OP:   bulk_op     <= cfg_wdata;
        CFG_DUMMY:     dummy_value <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// File: src/sfcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash command sequencer descriptor queue
// Short FIFO between the front end and the sequencer.
// ----------------------------------------------------------------------------
module sfcs_queue import sfcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sfcs_desc_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output sfcs_desc_t head
);

  sfcs_desc_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

endmodule

// File: src/sfcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash command sequencer back end
// Walks the pending action slots of one descriptor, one action per cycle
// unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module sfcs_back import sfcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sfcs_desc_t        q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ACT_W-1:0]  action,
  output logic [BYTE_W-1:0] spi_byte,
  output logic              last
);

  logic              cur_valid;
  sfcs_desc_t        cur;
  logic [SLOT_W-1:0] sel;
  slot_mask_t        remaining;
  logic              emit, done;
  logic [ACT_W-1:0]  act_sel;
  logic [BYTE_W-1:0] byte_sel;

  // Lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur.slots[i]) sel = SLOT_W'(i);
    end
  end

  assign remaining = cur.slots & (cur.slots - slot_mask_t'(1));
  assign done      = (remaining == '0);
  assign emit      = cur_valid && (!out_valid || out_ready);
  assign q_pop     = q_valid && (!cur_valid || (emit && done));

  // Action for the selected slot
  always_comb begin
    act_sel  = ACT_SEND;
    byte_sel = '0;
    case (sel)
      SLOT_CLOSE_RAISE, SLOT_RD_RAISE, SLOT_WREN_RAISE, SLOT_TAIL_RAISE: begin
        act_sel = ACT_RAISE;
      end
      SLOT_CLOSE_WAIT, SLOT_TAIL_WAIT: begin
        act_sel = ACT_WAIT;
      end
      SLOT_WREN_SEND: byte_sel = OP_WREN;
      SLOT_OPCODE:    byte_sel = cur.opcode;
      SLOT_ADDR_HI:   byte_sel = cur.addr[23:16];
      SLOT_ADDR_MID:  byte_sel = cur.addr[15:8];
      SLOT_ADDR_LO:   byte_sel = cur.addr[7:0];
      SLOT_BODY0, SLOT_BODY1, SLOT_BODY2: byte_sel = cur.body;
      default: begin
        act_sel = ACT_RAISE;
      end
    endcase
  end

  // Current descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
    end else if (emit && done) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end else if (emit) begin
      cur.slots <= remaining;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      action   <= act_sel;
      spi_byte <= byte_sel;
      last     <= done;
    end
  end

endmodule

// File: src/spi_flash_command_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI flash command sequencer
// Turns program, read, erase and ID requests into byte-level SPI actions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request per transaction:
//   req_type, address, data_byte, first, final_req. Output channel
//   (out_valid/out_ready) gives one action per transaction: action, spi_byte
//   and last, which marks the final action caused by a request.
//   cfg_we/cfg_index/cfg_wdata write the erase opcodes and the dummy byte.
//   A request is classified in the cycle it is accepted and queued; the
//   sequencer emits its actions one per cycle unless the receiver stalls,
//   the first one passing through the queue, the current-descriptor
//   register and the output register. A program or read byte that neither
//   opens nor closes a run is one action, so runs stream likewise at one
//   request per cycle. The two-entry queue lets requests keep arriving
//   while the sequencer works. When the receiver stalls, the output register
//   holds its action, the sequencer stops and the queue fills; in_ready drops
//   when it is full. Reset clears the cursor, run state and queue and
//   restores the register defaults. PAGE_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_top import sfcs_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [ADDR_W-1:0]    address,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 first,
  input  logic                 final_req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ACT_W-1:0]     action,
  output logic [BYTE_W-1:0]    spi_byte,
  output logic                 last
);

  logic       q_full, q_push, q_pop, q_valid;
  sfcs_desc_t q_wdata, q_head;

  sfcs_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .address   (address),
    .data_byte (data_byte),
    .first     (first),
    .final_req (final_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  sfcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  sfcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .spi_byte  (spi_byte),
    .last      (last)
  );

  // Front only stalls when the queue holds work
  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  // Queue never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");

  // Non-send actions carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action != ACT_SEND) |-> (spi_byte == '0))
    else $error("nonzero byte on raise or wait");

  // A request is only taken from the queue when present
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
